// ===== rtl/wsci_pkg.sv =====
// Shared types for the wave shaper curve interpolator.
// No dependencies; imported by the input channel interface and the top level.
package wsci_pkg;

    // Operation carried by an input item.
    typedef enum logic {
        OP_SHAPE = 1'b0,
        OP_WRITE = 1'b1
    } t_opcode;

endpackage

// ===== rtl/wsci_smp_if.sv =====
// Input channel of the wave shaper: valid/ready plus one item's fields.
// Depends on wsci_pkg for the opcode type.
interface wsci_smp_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 10
);
    import wsci_pkg::*;

    logic                          valid;
    logic                          ready;
    t_opcode                       opcode;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic        [INDEX_BITS-1:0]  entry_index;
    logic signed [SAMPLE_BITS-1:0] entry_value;
    logic                          last_frame;

    modport source (
        output valid, opcode, sample_in, entry_index, entry_value, last_frame,
        input  ready
    );

    modport sink (
        input  valid, opcode, sample_in, entry_index, entry_value, last_frame,
        output ready
    );
endinterface

// ===== rtl/wsci_res_if.sv =====
// Result channel of the wave shaper: valid/ready plus one shaped sample.
// No dependencies.
interface wsci_res_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          last_out;

    modport source (
        output valid, sample_out, last_out,
        input  ready
    );

    modport sink (
        input  valid, sample_out, last_out,
        output ready
    );
endinterface

// ===== rtl/waveshaper_curve_interpolator.sv =====
// Wave shaper with a loadable curve table and linear interpolation.
// Depends on wsci_pkg, wsci_smp_if and wsci_res_if.
//
// Usage:
// Items arrive on i_smp (valid/ready). A write item stores entry_value at
// entry_index in the curve table and yields no result. A shape item maps
// sample_in through the first curve_length entries of the table and yields
// one result item on o_res, carrying last_frame along as last_out.
// The curve length is set through i_cfg_wr_en / i_cfg_wr_data; the user must set it only
// while the block is idle, which the block does not enforce. Zero passes samples through unchanged.
//
// Timing: four register stages (scale multiply, table read, interpolation
// multiply, rounding/output). One item is taken every cycle while o_res is
// not stalled; the rate is set by the single write port and the dual read
// port of the curve memory, one of which each item uses once.
//
// Reset clears every stage valid bit and sets the curve length to zero.
// The curve table is not cleared and must be written before it is used.
// When the receiver holds o_res.ready low, the result stays on o_res and
// the stages behind it keep filling until each holds an item; only then
// does i_smp.ready fall. Nothing is dropped or repeated.
module waveshaper_curve_interpolator #(
    parameter int MAX_CURVE   = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int LEN_BITS    = $clog2(MAX_CURVE + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [LEN_BITS-1:0] i_cfg_wr_data,
    wsci_smp_if.sink            i_smp,
    wsci_res_if.source          o_res
);
    import wsci_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int IW = $clog2(MAX_CURVE);
    localparam int VW = IW + SB;

    localparam logic [SB-1:0]       SSIGN     = {1'b1, {(SB - 1){1'b0}}};
    localparam logic [LEN_BITS-1:0] LEN_LIMIT = LEN_BITS'(MAX_CURVE);
    localparam logic [IW:0]         IDX_LIMIT = (IW + 1)'(MAX_CURVE);

    // Curve length, held as length minus one (clamped to the table) and a
    // flag for the pass-through case.
    logic          r_len_zero;
    logic [IW-1:0] r_len_m1;
    logic [LEN_BITS-1:0] n_len_clamp;

    always_comb begin
        n_len_clamp = (i_cfg_wr_data > LEN_LIMIT) ? LEN_LIMIT : i_cfg_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_zero <= 1'b1;
            r_len_m1   <= '0;
        end else if (i_cfg_wr_en) begin
            r_len_zero <= (i_cfg_wr_data == '0);
            r_len_m1   <= IW'(n_len_clamp - 1'b1);
        end
    end

    // Stage handshakes: a stage takes a new item when it is empty or when
    // the stage ahead of it moves on in the same cycle.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4 = !r_v4 || o_res.ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign i_smp.ready = w_rdy1;

    logic w_in_take;
    assign w_in_take = i_smp.valid && w_rdy1;

    // Stage 1: the scale product v = (L-1) * (x + 2^(SB-1)).
    t_opcode       r_op1;
    logic [SB-1:0] r_smp1;
    logic          r_last1;
    logic [IW-1:0] r_idx1;
    logic [SB-1:0] r_val1;
    logic [VW-1:0] r_prod1;
    logic [VW-1:0] n_prod1;

    always_comb begin
        n_prod1 = VW'(r_len_m1) * VW'($unsigned(i_smp.sample_in) ^ SSIGN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op1   <= i_smp.opcode;
            r_smp1  <= $unsigned(i_smp.sample_in);
            r_last1 <= i_smp.last_frame;
            r_idx1  <= i_smp.entry_index;
            r_val1  <= $unsigned(i_smp.entry_value);
            r_prod1 <= n_prod1;
        end
    end

    // Stage 2: classify v and read the two neighboring entries. Writes go
    // into the table as they leave stage 1, so they stay in order with the
    // reads of the shape items around them.
    logic [SB-1:0] r_curve [MAX_CURVE];

    logic          r_last2;
    logic [SB-1:0] r_smp2;
    logic          r_pass2;
    logic          r_interp2;
    logic [SB-1:0] r_f2;
    logic [SB-1:0] r_rd0;
    logic [SB-1:0] r_rd1;

    logic          w_s1_shape;
    logic          w_s1_write;
    logic [IW-1:0] n_k;
    logic          n_low;
    logic          n_high;
    logic [IW-1:0] n_addr0;
    logic [IW-1:0] n_addr1;

    always_comb begin
        w_s1_shape = r_v1 && (r_op1 == OP_SHAPE);
        w_s1_write = r_v1 && (r_op1 == OP_WRITE) && ({1'b0, r_idx1} < IDX_LIMIT);
        n_k        = r_prod1[VW-1:SB];
        n_low      = (r_prod1 == '0);
        n_high     = (n_k >= r_len_m1);
        if (n_low) begin
            n_addr0 = '0;
        end else if (n_high) begin
            n_addr0 = r_len_m1;
        end else begin
            n_addr0 = n_k;
        end
        n_addr1 = n_k + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && w_s1_write) begin
            r_curve[r_idx1] <= r_val1;
        end
        if (w_rdy2 && w_s1_shape) begin
            r_rd0 <= r_curve[n_addr0];
            r_rd1 <= r_curve[n_addr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= w_s1_shape;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && w_s1_shape) begin
            r_last2   <= r_last1;
            r_smp2    <= r_smp1;
            r_pass2   <= r_len_zero;
            r_interp2 <= !r_len_zero && !n_low && !n_high;
            r_f2      <= r_prod1[SB-1:0];
        end
    end

    // Stage 3: base value and f * (c1 - c0) in offset binary. Outside the
    // interpolation range the difference is forced to zero, so the base
    // value passes unchanged.
    logic                 r_last3;
    logic [SB-1:0]        r_c0_3;
    logic signed [2*SB:0] r_p3;

    logic [SB-1:0]        n_c0;
    logic [SB-1:0]        n_c1;
    logic signed [SB:0]   n_diff;
    logic signed [2*SB:0] n_p;

    always_comb begin
        n_c0   = r_pass2 ? (r_smp2 ^ SSIGN) : (r_rd0 ^ SSIGN);
        n_c1   = r_rd1 ^ SSIGN;
        n_diff = r_interp2 ? ($signed({1'b0, n_c1}) - $signed({1'b0, n_c0}))
                           : '0;
        n_p    = (2 * SB + 1)'($signed({1'b0, r_f2})) * (2 * SB + 1)'(n_diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_last3 <= r_last2;
            r_c0_3  <= n_c0;
            r_p3    <= n_p;
        end
    end

    // Stage 4: add the base, round half up and return to two's complement.
    logic          r_last4;
    logic [SB-1:0] r_res4;

    logic signed [2*SB+1:0] n_sum;
    logic [SB-1:0]          n_res;

    always_comb begin
        n_sum = $signed({2'b00, r_c0_3, {SB{1'b0}}}) + (2 * SB + 2)'(r_p3)
              + $signed({{(SB + 2){1'b0}}, SSIGN});
        n_res = n_sum[2*SB-1:SB] ^ SSIGN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r_v3) begin
            r_last4 <= r_last3;
            r_res4  <= n_res;
        end
    end

    assign o_res.valid      = r_v4;
    assign o_res.sample_out = $signed(r_res4);
    assign o_res.last_out   = r_last4;

`ifndef SYNTHESIS
    // A write item leaving stage 1 must never turn into a result.
    a_write_no_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && (r_op1 == OP_WRITE) && w_rdy2) |=> !r_v2
    ) else $error("write item entered the result path");

    // Outside the interpolation range the slope term must vanish.
    a_flat_no_slope: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !r_interp2 && w_rdy3) |=> (r_p3 == '0)
    ) else $error("slope term nonzero outside interpolation range");

    // An item in stage 3 stays there while stage 4 is stalled.
    a_stage3_drain: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !w_rdy4) |=> (r_v3 && r_v4)
    ) else $error("stage 3 item lost during a stall");
`endif

endmodule
